/* sv/exl_pkg.sv */
// ----------------------------------------------------------------------------
// exl_pkg
// Shared types and constants of the expression lexer: token kinds, operator
// codes, scanner modes, the keyword table and the token record.
// ----------------------------------------------------------------------------
package exl_pkg;

	typedef enum logic [2:0] {
		TK_NUM     = 3'd0,
		TK_OP      = 3'd1,
		TK_OPEN    = 3'd2,
		TK_CLOSE   = 3'd3,
		TK_IDENT   = 3'd4,
		TK_END     = 3'd5,
		TK_INVALID = 3'd6
	} tok_kind_t;

	typedef enum logic [3:0] {
		OP_ADD    = 4'd0,
		OP_SUB    = 4'd1,
		OP_DIV    = 4'd2,
		OP_DIVEQ  = 4'd3,
		OP_MUL    = 4'd4,
		OP_GT     = 4'd5,
		OP_LT     = 4'd6,
		OP_ASSIGN = 4'd7,
		OP_EQ     = 4'd8,
		OP_IF     = 4'd9,
		OP_WHILE  = 4'd10,
		OP_LET    = 4'd11,
		OP_LAMBDA = 4'd12,
		OP_SWITCH = 4'd13,
		OP_CASE   = 4'd14
	} op_code_t;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_SLASH = 3'd1,
		MODE_COLON = 3'd2,
		MODE_NUM   = 3'd3,
		MODE_WORD  = 3'd4
	} lex_mode_t;

	localparam int NUM_W    = 31;
	localparam int START_W  = 12;
	localparam int LENGTH_W = 13;

	localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

	// keyword table: only the first KW_CHARS characters of a word are kept
	localparam int KW_CHARS = 6;
	localparam int KW_COUNT = 6;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"l", "e", "t", 8'h00, 8'h00, 8'h00},
		'{"l", "a", "m", "b", "d", "a"},
		'{"s", "w", "i", "t", "c", "h"},
		'{"c", "a", "s", "e", 8'h00, 8'h00}
	};

	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd5, 3'd3, 3'd6, 3'd6, 3'd4};

	typedef struct packed {
		tok_kind_t             kind;
		op_code_t              op;
		logic [NUM_W-1:0]      value;
		logic                  overflow;
		logic [START_W-1:0]    start;
		logic [LENGTH_W-1:0]   length;
		logic                  last;
	} token_t;

	// up to two tokens produced by one character
	typedef struct packed {
		token_t     first;
		token_t     second;
		logic [1:0] count;
	} tok_pair_t;

endpackage

/* sv/expression_lexer.sv */
// ----------------------------------------------------------------------------
// expression_lexer
// Streaming tokenizer: one character in per item, up to two tokens out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall / char_byte) carries one character per
//   item; byte 0 ends the line, flushes any pending token and emits an end
//   token. Output channel (out_valid / out_stall / token fields) carries one
//   token per item; last_of_run marks the last token a character caused.
//   A character is registered when accepted and scanned from that register
//   once the queue has room; its tokens are offered from the queue's head.
//   Throughput is one character per cycle while results are taken; the
//   output side moves one token per cycle, so characters that end a pending
//   token and emit one of their own (two results) are limited by that port.
//   A four-entry token queue sits between scanner and output: while it has
//   room for two tokens the scanner keeps taking characters even when the
//   receiver stalls; lacking that room, in_stall rises and holds the character.
//   Reset clears the scanner to idle at line position zero and empties the
//   queue; in_stall is low out of reset, so the block accepts items at once.
// ----------------------------------------------------------------------------
module expression_lexer #(
	parameter int MAX_LINE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_kind,
	output logic [3:0]  operator_code,
	output logic [30:0] number_value,
	output logic        number_overflow,
	output logic [11:0] ident_start,
	output logic [12:0] ident_length,
	output logic        last_of_run
);

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               room;
	logic               step;
	logic               pop;
	exl_pkg::tok_pair_t toks;
	exl_pkg::token_t    head;

	assign step     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_byte;
		end
	end

	exl_scanner #(
		.MAX_LINE(MAX_LINE)
	) u_scanner (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (char_s1),
		.toks   (toks)
	);

	exl_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.toks      (toks),
		.pop       (pop),
		.head      (head),
		.not_empty (out_valid),
		.room      (room)
	);

	assign token_kind      = head.kind;
	assign operator_code   = head.op;
	assign number_value    = head.value;
	assign number_overflow = head.overflow;
	assign ident_start     = head.start;
	assign ident_length    = head.length;
	assign last_of_run     = head.last;

endmodule

/* sv/exl_scanner.sv */
// ----------------------------------------------------------------------------
// exl_scanner
// Scanner state and token decode: takes one character per step, updates the
// mode, number accumulator, word registers and line position, and produces
// the flushed token and the token of the character itself.
// ----------------------------------------------------------------------------
module exl_scanner #(
	parameter int MAX_LINE = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          ch,
	output exl_pkg::tok_pair_t  toks
);

	localparam int LPOS_W = $clog2(MAX_LINE);
	localparam int WLEN_W = $clog2(MAX_LINE + 1);
	localparam int PROD_W = exl_pkg::NUM_W + 4;

	exl_pkg::lex_mode_t          mode_q, mode_d;
	logic [exl_pkg::NUM_W-1:0]   acc_q, acc_d;
	logic                        ovf_q, ovf_d;
	logic [WLEN_W-1:0]           wlen_q, wlen_d;
	logic [LPOS_W-1:0]           wstart_q, wstart_d;
	logic [LPOS_W-1:0]           lpos_q, lpos_d;
	logic [7:0]                  kbuf_q [exl_pkg::KW_CHARS];

	logic                        is_end, is_dig, is_alpha, is_blank;
	logic                        cont_slash, cont_colon, cont_num, cont_word;
	logic                        consumed, flushing;
	logic [PROD_W-1:0]           prod;
	logic                        prod_sat;
	logic                        kb_we;
	logic [2:0]                  kb_idx;

	exl_pkg::token_t             tok_flush, tok_main;
	logic                        main_vld;

	assign is_end   = (ch == 8'h00);
	assign is_dig   = ch inside {[8'h30:8'h39]};
	assign is_alpha = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	assign is_blank = ch inside {8'h20, [8'h09:8'h0D]};

	assign cont_slash = (mode_q == exl_pkg::MODE_SLASH) && (ch == "=");
	assign cont_colon = (mode_q == exl_pkg::MODE_COLON) && (ch == "=");
	assign cont_num   = (mode_q == exl_pkg::MODE_NUM) && is_dig;
	assign cont_word  = (mode_q == exl_pkg::MODE_WORD) && (is_alpha || is_dig);
	assign consumed   = cont_slash || cont_colon || cont_num || cont_word;
	assign flushing   = !consumed && (mode_q != exl_pkg::MODE_IDLE);

	// acc * 10 + digit
	assign prod = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + PROD_W'(ch[3:0]);
	assign prod_sat = (prod > PROD_W'(exl_pkg::NUM_MAX));

	// next state
	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		wlen_d   = wlen_q;
		wstart_d = wstart_q;
		lpos_d   = lpos_q;
		kb_we    = 1'b0;
		kb_idx   = 3'd0;
		if (step) begin
			if (is_end) begin
				mode_d   = exl_pkg::MODE_IDLE;
				acc_d    = '0;
				ovf_d    = 1'b0;
				wlen_d   = '0;
				wstart_d = '0;
				lpos_d   = '0;
			end else begin
				if (lpos_q < LPOS_W'(MAX_LINE - 1)) begin
					lpos_d = lpos_q + 1'b1;
				end
				if (cont_slash || cont_colon) begin
					mode_d = exl_pkg::MODE_IDLE;
				end else if (cont_num) begin
					if (prod_sat) begin
						acc_d = exl_pkg::NUM_MAX;
						ovf_d = 1'b1;
					end else begin
						acc_d = prod[exl_pkg::NUM_W-1:0];
					end
				end else if (cont_word) begin
					if (wlen_q < WLEN_W'(exl_pkg::KW_CHARS)) begin
						kb_we  = 1'b1;
						kb_idx = wlen_q[2:0];
					end
					if (wlen_q < WLEN_W'(MAX_LINE)) begin
						wlen_d = wlen_q + 1'b1;
					end
				end else begin
					mode_d = exl_pkg::MODE_IDLE;
					if (ch == "/") begin
						mode_d = exl_pkg::MODE_SLASH;
					end else if (ch == ":") begin
						mode_d = exl_pkg::MODE_COLON;
					end else if (is_dig) begin
						mode_d = exl_pkg::MODE_NUM;
						acc_d  = exl_pkg::NUM_W'(ch[3:0]);
						ovf_d  = 1'b0;
					end else if (is_alpha) begin
						mode_d   = exl_pkg::MODE_WORD;
						wstart_d = lpos_q;
						wlen_d   = WLEN_W'(1);
						kb_we    = 1'b1;
						kb_idx   = 3'd0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= exl_pkg::MODE_IDLE;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			wlen_q   <= '0;
			wstart_q <= '0;
			lpos_q   <= '0;
		end else begin
			mode_q   <= mode_d;
			acc_q    <= acc_d;
			ovf_q    <= ovf_d;
			wlen_q   <= wlen_d;
			wstart_q <= wstart_d;
			lpos_q   <= lpos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (kb_we) begin
			kbuf_q[kb_idx] <= ch;
		end
	end

	function automatic exl_pkg::token_t plain_tok(exl_pkg::tok_kind_t kind,
		exl_pkg::op_code_t op);
		exl_pkg::token_t t;
		t      = '0;
		t.kind = kind;
		t.op   = op;
		return t;
	endfunction

	// pending token, emitted when the current character ends it
	always_comb begin
		logic [exl_pkg::KW_COUNT-1:0] hit;
		logic                         found;
		int                           k;
		int                           j;
		hit   = '0;
		found = 1'b0;
		for (k = 0; k < exl_pkg::KW_COUNT; k++) begin
			hit[k] = (wlen_q == WLEN_W'(exl_pkg::KW_LEN[k]));
			for (j = 0; j < exl_pkg::KW_CHARS; j++) begin
				if (j < int'(exl_pkg::KW_LEN[k]) && kbuf_q[j] != exl_pkg::KW_TEXT[k][j]) begin
					hit[k] = 1'b0;
				end
			end
		end
		tok_flush = plain_tok(exl_pkg::TK_INVALID, exl_pkg::OP_ADD);
		case (mode_q)
			exl_pkg::MODE_SLASH: begin
				tok_flush = plain_tok(exl_pkg::TK_OP, exl_pkg::OP_DIV);
			end
			exl_pkg::MODE_NUM: begin
				tok_flush          = plain_tok(exl_pkg::TK_NUM, exl_pkg::OP_ADD);
				tok_flush.value    = acc_q;
				tok_flush.overflow = ovf_q;
			end
			exl_pkg::MODE_WORD: begin
				tok_flush        = plain_tok(exl_pkg::TK_IDENT, exl_pkg::OP_ADD);
				tok_flush.start  = exl_pkg::START_W'(wstart_q);
				tok_flush.length = exl_pkg::LENGTH_W'(wlen_q);
				for (k = 0; k < exl_pkg::KW_COUNT; k++) begin
					if (hit[k] && !found) begin
						found     = 1'b1;
						tok_flush = plain_tok(exl_pkg::TK_OP,
							exl_pkg::op_code_t'(4'(exl_pkg::OP_IF) + 4'(k)));
					end
				end
			end
			default: begin
				tok_flush = plain_tok(exl_pkg::TK_INVALID, exl_pkg::OP_ADD);
			end
		endcase
	end

	// token of the character itself
	always_comb begin
		tok_main = plain_tok(exl_pkg::TK_INVALID, exl_pkg::OP_ADD);
		main_vld = 1'b1;
		if (is_end) begin
			tok_main = plain_tok(exl_pkg::TK_END, exl_pkg::OP_ADD);
		end else if (cont_slash) begin
			tok_main = plain_tok(exl_pkg::TK_OP, exl_pkg::OP_DIVEQ);
		end else if (cont_colon) begin
			tok_main = plain_tok(exl_pkg::TK_OP, exl_pkg::OP_ASSIGN);
		end else if (cont_num || cont_word) begin
			main_vld = 1'b0;
		end else if (is_dig || is_alpha || is_blank) begin
			main_vld = 1'b0;
		end else begin
			case (ch)
				"+": tok_main = plain_tok(exl_pkg::TK_OP, exl_pkg::OP_ADD);
				"-": tok_main = plain_tok(exl_pkg::TK_OP, exl_pkg::OP_SUB);
				"*": tok_main = plain_tok(exl_pkg::TK_OP, exl_pkg::OP_MUL);
				">": tok_main = plain_tok(exl_pkg::TK_OP, exl_pkg::OP_GT);
				"<": tok_main = plain_tok(exl_pkg::TK_OP, exl_pkg::OP_LT);
				"=": tok_main = plain_tok(exl_pkg::TK_OP, exl_pkg::OP_EQ);
				"(": tok_main = plain_tok(exl_pkg::TK_OPEN, exl_pkg::OP_ADD);
				")": tok_main = plain_tok(exl_pkg::TK_CLOSE, exl_pkg::OP_ADD);
				"/", ":": main_vld = 1'b0;
				default: tok_main = plain_tok(exl_pkg::TK_INVALID, exl_pkg::OP_ADD);
			endcase
		end
	end

	always_comb begin
		toks = '0;
		if (flushing) begin
			toks.first       = tok_flush;
			toks.second      = tok_main;
			toks.first.last  = !main_vld;
			toks.second.last = 1'b1;
			toks.count       = main_vld ? 2'd2 : 2'd1;
		end else begin
			toks.first      = tok_main;
			toks.first.last = 1'b1;
			toks.count      = main_vld ? 2'd1 : 2'd0;
		end
		if (!step) begin
			toks.count = 2'd0;
		end
	end

endmodule

/* sv/exl_token_fifo.sv */
// ----------------------------------------------------------------------------
// exl_token_fifo
// Four-entry token queue: takes up to two tokens a cycle, hands out one a
// cycle on the result channel whenever it is popped.
// ----------------------------------------------------------------------------
module exl_token_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  exl_pkg::tok_pair_t  toks,
	input  logic                pop,
	output exl_pkg::token_t     head,
	output logic                not_empty,
	output logic                room
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	exl_pkg::token_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  wr_nxt;

	assign wr_nxt    = wr_q + 1'b1;
	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	// space for a full pair regardless of what leaves this cycle
	assign room      = (cnt_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (toks.count != 2'd0) begin
			mem_q[wr_q] <= toks.first;
		end
		if (toks.count == 2'd2) begin
			mem_q[wr_nxt] <= toks.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(toks.count);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(toks.count) - CNT_W'(pop);
		end
	end

endmodule

/* tb/exl_token_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exl_token_checker
// Watches both channels of the expression lexer. Every accepted character
// runs through a behavioural scanner that queues the tokens it should cause;
// every accepted token is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module exl_token_checker #(
	parameter int MAX_LINE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  token_kind,
	input  logic [3:0]  operator_code,
	input  logic [30:0] number_value,
	input  logic        number_overflow,
	input  logic [11:0] ident_start,
	input  logic [12:0] ident_length,
	input  logic        last_of_run,
	output int          fail_count,
	output int          tokens_pending
);

	// operator field of tokens that carry no operator
	localparam exl_pkg::op_code_t NO_OP = exl_pkg::OP_ADD;

	string             kw_words [6] = '{"if", "while", "let", "lambda", "switch", "case"};
	exl_pkg::op_code_t kw_ops [6]   = '{exl_pkg::OP_IF, exl_pkg::OP_WHILE, exl_pkg::OP_LET,
		exl_pkg::OP_LAMBDA, exl_pkg::OP_SWITCH, exl_pkg::OP_CASE};

	// scanner state
	exl_pkg::lex_mode_t           mode;
	logic [exl_pkg::NUM_W-1:0]    acc;
	logic                         acc_ovf;
	logic [7:0]                   kw_buf [exl_pkg::KW_CHARS];
	logic [exl_pkg::LENGTH_W-1:0] word_len;
	logic [exl_pkg::START_W-1:0]  word_start;
	logic [exl_pkg::START_W-1:0]  line_pos;

	exl_pkg::token_t expected_tokens [$];
	exl_pkg::token_t step_tokens [$];
	exl_pkg::token_t want;
	int              mismatches;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic void add_token(input exl_pkg::tok_kind_t kind,
			input exl_pkg::op_code_t op,
			input logic [exl_pkg::NUM_W-1:0] value, input logic ovf,
			input logic [exl_pkg::START_W-1:0] start,
			input logic [exl_pkg::LENGTH_W-1:0] len);
		exl_pkg::token_t t;
		t.kind     = kind;
		t.op       = op;
		t.value    = value;
		t.overflow = ovf;
		t.start    = start;
		t.length   = len;
		t.last     = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void add_digit(input logic [7:0] c);
		logic [34:0] v;
		v = 35'(acc) * 35'd10 + 35'(c - 8'h30);
		if (v > 35'(exl_pkg::NUM_MAX)) begin
			acc     = exl_pkg::NUM_MAX;
			acc_ovf = 1'b1;
		end else begin
			acc = v[exl_pkg::NUM_W-1:0];
		end
	endfunction

	function automatic void add_letter(input logic [7:0] c);
		if (word_len < exl_pkg::KW_CHARS)
			kw_buf[word_len] = c;
		if (word_len < MAX_LINE)
			word_len++;
	endfunction

	// emit whatever token is still being built and return to idle
	task automatic close_pending();
		logic hit;
		logic same;
		case (mode)
			exl_pkg::MODE_SLASH:
				add_token(exl_pkg::TK_OP, exl_pkg::OP_DIV, '0, 1'b0, '0, '0);
			exl_pkg::MODE_COLON:
				add_token(exl_pkg::TK_INVALID, NO_OP, '0, 1'b0, '0, '0);
			exl_pkg::MODE_NUM:
				add_token(exl_pkg::TK_NUM, NO_OP, acc, acc_ovf, '0, '0);
			exl_pkg::MODE_WORD: begin
				hit = 1'b0;
				for (int k = 0; k < 6; k++) begin
					if (!hit && word_len == exl_pkg::LENGTH_W'(kw_words[k].len())) begin
						same = 1'b1;
						for (int i = 0; i < kw_words[k].len(); i++)
							if (kw_buf[i] != kw_words[k][i])
								same = 1'b0;
						if (same) begin
							add_token(exl_pkg::TK_OP, kw_ops[k], '0, 1'b0, '0, '0);
							hit = 1'b1;
						end
					end
				end
				if (!hit)
					add_token(exl_pkg::TK_IDENT, NO_OP, '0, 1'b0, word_start, word_len);
			end
			default: ;
		endcase
		mode = exl_pkg::MODE_IDLE;
	endtask

	task automatic scan_char(input logic [7:0] c);
		logic            taken;
		exl_pkg::token_t t;
		step_tokens.delete();
		taken = 1'b0;
		if (c == 8'd0) begin
			close_pending();
			add_token(exl_pkg::TK_END, NO_OP, '0, 1'b0, '0, '0);
			line_pos   = '0;
			acc        = '0;
			acc_ovf    = 1'b0;
			word_len   = '0;
			word_start = '0;
		end else begin
			if (mode == exl_pkg::MODE_SLASH && c == "=") begin
				add_token(exl_pkg::TK_OP, exl_pkg::OP_DIVEQ, '0, 1'b0, '0, '0);
				mode  = exl_pkg::MODE_IDLE;
				taken = 1'b1;
			end else if (mode == exl_pkg::MODE_COLON && c == "=") begin
				add_token(exl_pkg::TK_OP, exl_pkg::OP_ASSIGN, '0, 1'b0, '0, '0);
				mode  = exl_pkg::MODE_IDLE;
				taken = 1'b1;
			end else if (mode == exl_pkg::MODE_NUM && is_digit(c)) begin
				add_digit(c);
				taken = 1'b1;
			end else if (mode == exl_pkg::MODE_WORD && (is_alpha(c) || is_digit(c))) begin
				add_letter(c);
				taken = 1'b1;
			end else begin
				close_pending();
			end

			// a character that ended a token is then taken on its own
			if (!taken) begin
				case (c)
					"+": add_token(exl_pkg::TK_OP, exl_pkg::OP_ADD, '0, 1'b0, '0, '0);
					"-": add_token(exl_pkg::TK_OP, exl_pkg::OP_SUB, '0, 1'b0, '0, '0);
					"*": add_token(exl_pkg::TK_OP, exl_pkg::OP_MUL, '0, 1'b0, '0, '0);
					">": add_token(exl_pkg::TK_OP, exl_pkg::OP_GT, '0, 1'b0, '0, '0);
					"<": add_token(exl_pkg::TK_OP, exl_pkg::OP_LT, '0, 1'b0, '0, '0);
					"=": add_token(exl_pkg::TK_OP, exl_pkg::OP_EQ, '0, 1'b0, '0, '0);
					"(": add_token(exl_pkg::TK_OPEN, NO_OP, '0, 1'b0, '0, '0);
					")": add_token(exl_pkg::TK_CLOSE, NO_OP, '0, 1'b0, '0, '0);
					"/": mode = exl_pkg::MODE_SLASH;
					":": mode = exl_pkg::MODE_COLON;
					default: begin
						if (is_digit(c)) begin
							mode    = exl_pkg::MODE_NUM;
							acc     = '0;
							acc_ovf = 1'b0;
							add_digit(c);
						end else if (is_alpha(c)) begin
							mode       = exl_pkg::MODE_WORD;
							word_start = line_pos;
							word_len   = '0;
							add_letter(c);
						end else if (!(c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
							add_token(exl_pkg::TK_INVALID, NO_OP, '0, 1'b0, '0, '0);
						end
					end
				endcase
			end

			if (line_pos < MAX_LINE - 1)
				line_pos++;
		end

		if (step_tokens.size() > 0) begin
			t = step_tokens[step_tokens.size() - 1];
			t.last = 1'b1;
			step_tokens[step_tokens.size() - 1] = t;
		end
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
	endtask

	function automatic int field_differs(input string field, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode       = exl_pkg::MODE_IDLE;
			acc        = '0;
			acc_ovf    = 1'b0;
			word_len   = '0;
			word_start = '0;
			line_pos   = '0;
			for (int i = 0; i < exl_pkg::KW_CHARS; i++)
				kw_buf[i] = 8'd0;
			expected_tokens.delete();
			mismatches = 0;
			fail_count     <= 0;
			tokens_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_tokens.size() == 0) begin
					$error("token with none expected: kind %0d op %0d", token_kind,
						operator_code);
					mismatches++;
				end else begin
					want = expected_tokens.pop_front();
					mismatches += field_differs("token_kind", 32'(want.kind), 32'(token_kind));
					mismatches += field_differs("operator_code", 32'(want.op),
						32'(operator_code));
					mismatches += field_differs("number_value", 32'(want.value),
						32'(number_value));
					mismatches += field_differs("number_overflow", 32'(want.overflow),
						32'(number_overflow));
					mismatches += field_differs("ident_start", 32'(want.start),
						32'(ident_start));
					mismatches += field_differs("ident_length", 32'(want.length),
						32'(ident_length));
					mismatches += field_differs("last_of_run", 32'(want.last),
						32'(last_of_run));
				end
			end
			if (in_valid && !in_stall)
				scan_char(char_byte);
			fail_count     <= mismatches;
			tokens_pending <= expected_tokens.size();
		end
	end

endmodule

/* tb/tb_expression_lexer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_expression_lexer
// Feeds the lexer a directed line and a few hundred random characters,
// mostly well-formed lines of words, numbers and operators with broken
// pieces and stray bytes mixed in, while both sides idle in random bursts.
// The checker beside the block judges every token.
// ----------------------------------------------------------------------------
module tb_expression_lexer;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  token_kind;
	logic [3:0]  operator_code;
	logic [30:0] number_value;
	logic        number_overflow;
	logic [11:0] ident_start;
	logic [12:0] ident_length;
	logic        last_of_run;
	int          fail_count;
	int          tokens_pending;

	int   chars_sent = 0;
	int   gap_pct    = 0;
	int   stall_pct  = 0;
	logic calm       = 1'b0;

	string keywords [6]       = '{"if", "while", "let", "lambda", "switch", "case"};
	string near_words [12]    = '{"iff", "whil", "lets", "lambdas", "switc", "Case", "IF",
		"case1", "le", "lambd", "whiles", "i"};
	string op_texts [11]      = '{"+", "-", "/", "/=", "*", ">", "<", ":=", "=", "(", ")"};
	string limit_numbers [6]  = '{"2147483647", "2147483648", "214748364", "0",
		"000000000012", "99999999999999"};

	expression_lexer dut (.*);

	exl_token_checker token_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_blank();
		int r;
		r = $urandom_range(8, 13);
		return (r == 8) ? 8'd32 : 8'(r);
	endfunction

	task automatic send_char(input logic [7:0] c);
		in_valid  <= 1'b1;
		char_byte <= c;
		do @(posedge clk); while (in_stall);
		chars_sent++;
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid  <= 1'b0;
			char_byte <= 8'($urandom);
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// hold the sender off until every token owed has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		for (int w = 0; w < 5000 && tokens_pending != 0; w++)
			@(posedge clk);
	endtask

	// receiver stalls in random bursts
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int base;
		int line_no;
		int n;
		in_valid  = 1'b0;
		char_byte = 8'd0;
		arst_n    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed line: keyword, identifier, assignment, saturating number,
		// both slash forms, every single operator but plus, lone colon, blank, stray
		// byte and a word flushed by end of line
		gap_pct   = 10;
		stall_pct = 10;
		send_text("if(x:=9999999999)/=/*-<>=:)\t");
		send_char(8'hFF);
		send_text("q");
		send_char(8'd0);
		drain_results();

		base    = chars_sent;
		line_no = 0;
		while (chars_sent - base < 520) begin
			if (chars_sent - base >= 420)
				calm = 1'b1;
			if (calm) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else if (line_no % 4 == 0) begin
				gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
			end
			if (line_no % 9 == 4)
				drain_results();

			repeat ($urandom_range(1, 10)) begin
				case ($urandom_range(0, 12))
					0, 1: send_text(keywords[$urandom_range(0, 5)]);
					2:    send_text(near_words[$urandom_range(0, 11)]);
					3, 4: begin
						n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40)
							: $urandom_range(1, 8);
						send_char(rand_letter());
						repeat (n - 1)
							send_char($urandom_range(0, 3) == 0 ? rand_digit() : rand_letter());
					end
					5, 6: begin
						if ($urandom_range(0, 5) == 0)
							send_text(limit_numbers[$urandom_range(0, 5)]);
						else
							repeat ($urandom_range(1, 12)) send_char(rand_digit());
					end
					10:   send_char(rand_blank());
					11: begin
						// colon or slash followed by any nonzero byte
						send_char($urandom_range(0, 1) ? ":" : "/");
						send_char(8'($urandom_range(1, 255)));
					end
					12:   send_char(8'($urandom_range(1, 255)));
					default: send_text(op_texts[$urandom_range(0, 10)]);
				endcase
				if ($urandom_range(0, 1))
					send_char(rand_blank());
			end
			send_char(8'd0);
			line_no++;
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && tokens_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/exl_pkg.sv
sv/exl_scanner.sv
sv/exl_token_fifo.sv
sv/expression_lexer.sv
tb/exl_token_checker.sv
tb/tb_expression_lexer.sv
